// ===== rtl/core/emnm_pkg.sv =====
// Shared types, widths, constants and arithmetic helpers for the Euler model matrix block.
`timescale 1ns / 1ps
`default_nettype none
package emnm_pkg;

  localparam int AW  = 17;      // angle field width
  localparam int SW  = 24;      // Q8.16 scale width
  localparam int PW  = 32;      // Q16.16 width
  localparam int ZW  = 33;      // CORDIC angle accumulator
  localparam int XW  = 34;      // CORDIC x/y
  localparam int RW  = 33;      // rotation entries and Q30 products
  localparam int PRW = 2 * RW;
  localparam int MW  = 40;      // rounded product before saturation
  localparam int NW  = 36;      // divider numerator and quotient bits
  localparam int DW  = 33;      // divider denominator bits

  localparam logic signed [XW-1:0] CORDIC_X0 = XW'(652032874);
  localparam logic signed [ZW-1:0] DEG_TO_RAD = ZW'(146409);
  localparam logic signed [PW-1:0] ONE_Q16 = PW'(65536);

  localparam logic       KIND_MODEL  = 1'b0;
  localparam logic       KIND_NORMAL = 1'b1;
  localparam logic [2:0] SLOT_POS    = 3'd3;
  localparam logic [2:0] SLOT_LAST   = 3'd6;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 neg;
  } cord_t;

  typedef struct packed {
    logic signed [SW-1:0] us;
    logic signed [SW-1:0] ax;
    logic signed [SW-1:0] ay;
    logic signed [SW-1:0] az;
    logic signed [PW-1:0] px;
    logic signed [PW-1:0] py;
    logic signed [PW-1:0] pz;
    logic                 nrm;
  } side_t;

  typedef struct packed {
    logic signed [PW-1:0] px;
    logic signed [PW-1:0] py;
    logic signed [PW-1:0] pz;
    logic                 nrm;
  } pos_t;

  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic [30:0] v;
    case (i)
      0: v = 31'd843314857;   1: v = 31'd497837829;   2: v = 31'd263043837;
      3: v = 31'd133525159;   4: v = 31'd67021687;    5: v = 31'd33543516;
      6: v = 31'd16775851;    7: v = 31'd8388437;     8: v = 31'd4194283;
      9: v = 31'd2097149;     10: v = 31'd1048576;    11: v = 31'd524288;
      12: v = 31'd262144;     13: v = 31'd131072;     14: v = 31'd65536;
      15: v = 31'd32768;      16: v = 31'd16384;      17: v = 31'd8192;
      18: v = 31'd4096;       19: v = 31'd2048;       20: v = 31'd1024;
      21: v = 31'd512;        22: v = 31'd256;        23: v = 31'd128;
      24: v = 31'd64;         25: v = 31'd32;         26: v = 31'd16;
      27: v = 31'd8;          28: v = 31'd4;          29: v = 31'd2;
      default: v = 31'd0;
    endcase
    return signed'({2'b00, v});
  endfunction

  // Q30 product with round to nearest, floor shift
  function automatic logic signed [MW-1:0] mul30(input logic signed [RW-1:0] a,
                                                 input logic signed [RW-1:0] b);
    logic signed [PRW-1:0] p;
    p = PRW'(a) * PRW'(b) + PRW'(64'sd536870912);
    return MW'(p >>> 30);
  endfunction

  function automatic logic signed [PW-1:0] sat32(input logic signed [MW-1:0] v);
    logic signed [PW-1:0] r;
    if (v > MW'(64'sd2147483647)) r = PW'(32'sh7fffffff);
    else if (v < -MW'(64'sd2147483648)) r = PW'(32'sh80000000);
    else r = PW'(v);
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/euler_model_normal_matrix_top.sv =====
// Top level: Euler angle model and normal matrix pipeline with column serializer.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | angles, scales, position, want_normal
//  out_    | output    | out_valid/out_stall| kind, column, four entries, last flag
//  cfg_    | input     | cfg_valid/cfg_ready| vertical scale, Q8.16
//
// The pipeline takes an object in any cycle that it advances. The serializer sends
// one column per cycle while out_stall is low, four per object or seven with the
// normal matrix, so that sets the sustained rate.
// Synchronous reset clears valid bits and sets the vertical scale to 1.0.
// A stall on the result side freezes every stage; nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none
module euler_model_normal_matrix_top import emnm_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic signed [AW-1:0] in_heading_angle,
  input  wire logic signed [AW-1:0] in_pitch_angle,
  input  wire logic signed [AW-1:0] in_bank_angle,
  input  wire logic signed [SW-1:0] in_uniform_scale,
  input  wire logic signed [SW-1:0] in_axis_scale_x,
  input  wire logic signed [SW-1:0] in_axis_scale_y,
  input  wire logic signed [SW-1:0] in_axis_scale_z,
  input  wire logic signed [PW-1:0] in_position_x,
  input  wire logic signed [PW-1:0] in_position_y,
  input  wire logic signed [PW-1:0] in_position_z,
  input  wire logic                 in_want_normal,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_matrix_kind,
  output logic [1:0]                out_column_number,
  output logic signed [PW-1:0]      out_entry_0,
  output logic signed [PW-1:0]      out_entry_1,
  output logic signed [PW-1:0]      out_entry_2,
  output logic signed [PW-1:0]      out_entry_3,
  output logic                      out_last_column,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic signed [SW-1:0] cfg_data
);

  logic                 en;
  logic signed [SW-1:0] vs_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) vs_r <= SW'(65536);
    else if (cfg_valid && cfg_ready) vs_r <= cfg_data;
  end

  // front end
  logic signed [AW-1:0] ang [3];
  side_t                side_in;
  assign ang[0] = in_heading_angle;
  assign ang[1] = in_pitch_angle;
  assign ang[2] = in_bank_angle;
  assign side_in = '{us: in_uniform_scale, ax: in_axis_scale_x, ay: in_axis_scale_y,
                     az: in_axis_scale_z, px: in_position_x, py: in_position_y,
                     pz: in_position_z, nrm: in_want_normal};

  logic  a_v, c_v, r_v;
  cord_t a_cord [3], c_cord [3];
  side_t a_side, c_side;
  logic signed [RW-1:0] r_m [9];
  logic signed [PW-1:0] s3 [3];
  pos_t  r_pos;

  emnm_angle u_angle (
    .clk, .rst_n, .en, .valid_in(in_valid), .ang_in(ang), .side_in,
    .valid_out(a_v), .cord_out(a_cord), .side_out(a_side)
  );

  emnm_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
    .clk, .rst_n, .en, .valid_in(a_v), .cord_in(a_cord), .side_in(a_side),
    .valid_out(c_v), .cord_out(c_cord), .side_out(c_side)
  );

  emnm_rot u_rot (
    .clk, .rst_n, .en, .valid_in(c_v), .cord_in(c_cord), .side_in(c_side),
    .valid_out(r_v), .r_out(r_m), .s3_out(s3), .pos_out(r_pos)
  );

  // model entries and divider operands
  logic                 m_v_r;
  logic signed [PW-1:0] me_r [9];
  pos_t                 mp_r;
  logic [NW-1:0]        dn_r [9];
  logic [DW-1:0]        dd_r [9];
  logic                 dneg_r [9], dz_r [9];
  logic signed [55:0]   vy_prod;

  assign vy_prod = 56'(r_pos.py) * 56'(vs_r) + 56'sd32768;

  always_ff @(posedge clk) begin
    if (!rst_n) m_v_r <= 1'b0;
    else if (en) m_v_r <= r_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        logic signed [RW-1:0] sc;
        logic [NW-1:0]        un, ud;
        sc = RW'(s3[i % 3]);
        me_r[i]   <= sat32(mul30(r_m[i], sc));
        un        = NW'(r_m[i][RW-1] ? -r_m[i] : r_m[i]) << 2;
        ud        = NW'(sc[RW-1] ? -sc : sc);
        dn_r[i]   <= 2 * un + ud;
        dd_r[i]   <= DW'(2 * ud);
        dneg_r[i] <= r_m[i][RW-1] ^ sc[RW-1];
        dz_r[i]   <= (sc == '0);
      end
      mp_r <= '{px: r_pos.px, py: sat32(MW'(vy_prod >>> 16)), pz: r_pos.pz,
                nrm: r_pos.nrm};
    end
  end

  // dividers, with the model data delayed alongside
  logic signed [PW-1:0] nq [9];
  for (genvar i = 0; i < 9; i++) begin : g_div
    emnm_div u_div (
      .clk, .en, .num_in(dn_r[i]), .den_in(dd_r[i]), .neg_in(dneg_r[i]),
      .zero_in(dz_r[i]), .res_out(nq[i])
    );
  end

  logic                 dv_r [NW];
  logic signed [PW-1:0] dme_r [NW][9];
  pos_t                 dmp_r [NW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NW; k++) dv_r[k] <= 1'b0;
    end else if (en) begin
      dv_r[0] <= m_v_r;
      for (int k = 1; k < NW; k++) dv_r[k] <= dv_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dme_r[0] <= me_r;
      dmp_r[0] <= mp_r;
      for (int k = 1; k < NW; k++) begin
        dme_r[k] <= dme_r[k-1];
        dmp_r[k] <= dmp_r[k-1];
      end
    end
  end

  // column serializer
  logic                 busy_r;
  logic [2:0]           col_r;
  logic signed [PW-1:0] hm_r [9];
  logic signed [PW-1:0] hq_r [9];
  pos_t                 hp_r;
  logic                 done;

  assign done     = busy_r && !out_stall && out_last_column;
  assign en       = !busy_r || done;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      col_r  <= '0;
    end else if (en) begin
      busy_r <= dv_r[NW-1];
      col_r  <= '0;
    end else if (!out_stall) begin
      col_r <= col_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hm_r <= dme_r[NW-1];
      hq_r <= nq;
      hp_r <= dmp_r[NW-1];
    end
  end

  logic [3:0] i0, i1, i2;
  assign i0 = 4'(col_r[1:0]);
  assign i1 = i0 + 4'd3;
  assign i2 = i0 + 4'd6;

  assign out_valid         = busy_r;
  assign out_column_number = col_r[1:0];
  assign out_last_column   = (col_r == SLOT_POS && !hp_r.nrm) || col_r == SLOT_LAST;

  always_comb begin
    out_matrix_kind = KIND_MODEL;
    out_entry_0 = '0;
    out_entry_1 = '0;
    out_entry_2 = '0;
    out_entry_3 = '0;
    if (col_r == SLOT_POS) begin
      out_entry_0 = hp_r.px;
      out_entry_1 = hp_r.py;
      out_entry_2 = hp_r.pz;
      out_entry_3 = ONE_Q16;
    end else if (col_r > SLOT_POS) begin
      out_matrix_kind = KIND_NORMAL;
      out_entry_0 = hq_r[i0];
      out_entry_1 = hq_r[i1];
      out_entry_2 = hq_r[i2];
    end else begin
      out_entry_0 = hm_r[i0];
      out_entry_1 = hm_r[i1];
      out_entry_2 = hm_r[i2];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/emnm_angle.sv =====
// Angle reduction stage: wrap to a full turn, fold to +-90 degrees, scale to Q30 radians.
`timescale 1ns / 1ps
`default_nettype none
module emnm_angle import emnm_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 valid_in,
  input  wire logic signed [AW-1:0] ang_in [3],
  input  wire side_t                side_in,
  output logic                      valid_out,
  output cord_t                     cord_out [3],
  output side_t                     side_out
);

  function automatic cord_t reduce(input logic signed [AW-1:0] a);
    logic signed [18:0] s;
    logic [17:0]        u;
    logic signed [16:0] m;
    cord_t              c;
    s = 19'(a) + 19'sd92160;
    u = s[17:0];
    if (u >= 18'd138240) u = u - 18'd138240;
    else if (u >= 18'd92160) u = u - 18'd92160;
    else if (u >= 18'd46080) u = u - 18'd46080;
    m = signed'({1'b0, u[15:0]});
    if (m > 17'sd23040) m = m - 17'sd46080;
    c.neg = 1'b0;
    if (m > 17'sd11520) begin
      m = 17'sd23040 - m;
      c.neg = 1'b1;
    end else if (m < -17'sd11520) begin
      m = -17'sd23040 - m;
      c.neg = 1'b1;
    end
    c.x = CORDIC_X0;
    c.y = '0;
    c.z = ZW'(m) * DEG_TO_RAD;
    return c;
  endfunction

  logic  valid_r;
  cord_t cord_r [3];
  side_t side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else if (en) valid_r <= valid_in;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) cord_r[l] <= reduce(ang_in[l]);
      side_r <= side_in;
    end
  end

  assign valid_out = valid_r;
  assign cord_out  = cord_r;
  assign side_out  = side_r;

endmodule
`default_nettype wire

// ===== rtl/core/emnm_cordic.sv =====
// CORDIC rotation pipeline: one micro-rotation per register stage, three angle lanes.
`timescale 1ns / 1ps
`default_nettype none
module emnm_cordic import emnm_pkg::*; #(
  parameter int STAGES = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  en,
  input  wire logic  valid_in,
  input  wire cord_t cord_in [3],
  input  wire side_t side_in,
  output logic       valid_out,
  output cord_t      cord_out [3],
  output side_t      side_out
);

  function automatic cord_t step(input cord_t c, input int i);
    cord_t o;
    o = c;
    if (c.z >= 0) begin
      o.x = c.x - (c.y >>> i);
      o.y = c.y + (c.x >>> i);
      o.z = c.z - atan_q30(i);
    end else begin
      o.x = c.x + (c.y >>> i);
      o.y = c.y - (c.x >>> i);
      o.z = c.z + atan_q30(i);
    end
    return o;
  endfunction

  logic  vld_r  [STAGES];
  cord_t cr_r   [STAGES][3];
  side_t side_r [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[i] <= 1'b0;
      else if (en) vld_r[i] <= (i == 0) ? valid_in : vld_r[(i == 0) ? 0 : i - 1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 3; l++)
          cr_r[i][l] <= step((i == 0) ? cord_in[l] : cr_r[(i == 0) ? 0 : i - 1][l], i);
        side_r[i] <= (i == 0) ? side_in : side_r[(i == 0) ? 0 : i - 1];
      end
    end
  end

  assign valid_out = vld_r[STAGES-1];
  assign cord_out  = cr_r[STAGES-1];
  assign side_out  = side_r[STAGES-1];

endmodule
`default_nettype wire

// ===== rtl/core/emnm_rot.sv =====
// Rotation matrix build and scale products over three register stages.
`timescale 1ns / 1ps
`default_nettype none
module emnm_rot import emnm_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 valid_in,
  input  wire cord_t                cord_in [3],
  input  wire side_t                side_in,
  output logic                      valid_out,
  output logic signed [RW-1:0]      r_out [9],
  output logic signed [PW-1:0]      s3_out [3],
  output pos_t                      pos_out
);

  logic signed [RW-1:0] sn [3];
  logic signed [RW-1:0] cs [3];
  logic signed [2*SW-1:0] sp_prod [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      sn[l] = RW'(cord_in[l].y);
      cs[l] = cord_in[l].neg ? RW'(-cord_in[l].x) : RW'(cord_in[l].x);
    end
    sp_prod[0] = (2*SW)'(side_in.us) * (2*SW)'(side_in.ax) + (2*SW)'(32768);
    sp_prod[1] = (2*SW)'(side_in.us) * (2*SW)'(side_in.ay) + (2*SW)'(32768);
    sp_prod[2] = (2*SW)'(side_in.us) * (2*SW)'(side_in.az) + (2*SW)'(32768);
  end

  // lane 0 heading, 1 pitch, 2 bank
  logic                 v1_r, v2_r, v3_r;
  logic signed [RW-1:0] p1_r [10];
  logic signed [RW-1:0] sh1_r, ch1_r, sp1_r;
  logic signed [RW-1:0] p2_r [10];
  logic signed [RW-1:0] t2_r [4];
  logic signed [RW-1:0] sp2_r;
  logic signed [PW-1:0] s1_r [3], s2_r [3], s3_r [3];
  pos_t                 q1_r, q2_r, q3_r;
  logic signed [RW-1:0] r3_r [9];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= valid_in;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r[0] <= RW'(mul30(cs[0], cs[2]));
      p1_r[1] <= RW'(mul30(sn[1], sn[2]));
      p1_r[2] <= RW'(mul30(cs[0], sn[2]));
      p1_r[3] <= RW'(mul30(sn[1], cs[2]));
      p1_r[4] <= RW'(mul30(sn[0], cs[1]));
      p1_r[5] <= RW'(mul30(cs[1], sn[2]));
      p1_r[6] <= RW'(mul30(cs[1], cs[2]));
      p1_r[7] <= RW'(mul30(sn[0], cs[2]));
      p1_r[8] <= RW'(mul30(sn[0], sn[2]));
      p1_r[9] <= RW'(mul30(cs[0], cs[1]));
      sh1_r   <= sn[0];
      ch1_r   <= cs[0];
      sp1_r   <= sn[1];
      for (int c = 0; c < 3; c++) s1_r[c] <= PW'(sp_prod[c] >>> 16);
      q1_r    <= '{px: side_in.px, py: side_in.py, pz: side_in.pz, nrm: side_in.nrm};

      // triple terms: heading-side factor times the pitch product
      t2_r[0] <= RW'(mul30(sh1_r, p1_r[1]));
      t2_r[1] <= RW'(mul30(sh1_r, p1_r[3]));
      t2_r[2] <= RW'(mul30(ch1_r, p1_r[1]));
      t2_r[3] <= RW'(mul30(ch1_r, p1_r[3]));
      p2_r    <= p1_r;
      sp2_r   <= sp1_r;
      s2_r    <= s1_r;
      q2_r    <= q1_r;

      r3_r[0] <= p2_r[0] + t2_r[0];
      r3_r[1] <= t2_r[1] - p2_r[2];
      r3_r[2] <= p2_r[4];
      r3_r[3] <= p2_r[5];
      r3_r[4] <= p2_r[6];
      r3_r[5] <= -sp2_r;
      r3_r[6] <= t2_r[2] - p2_r[7];
      r3_r[7] <= p2_r[8] + t2_r[3];
      r3_r[8] <= p2_r[9];
      s3_r    <= s2_r;
      q3_r    <= q2_r;
    end
  end

  assign valid_out = v3_r;
  assign r_out     = r3_r;
  assign s3_out    = s3_r;
  assign pos_out   = q3_r;

endmodule
`default_nettype wire

// ===== rtl/core/emnm_div.sv =====
// Pipelined restoring divider lane, one quotient bit per stage, signed saturated result.
`timescale 1ns / 1ps
`default_nettype none
module emnm_div import emnm_pkg::*; (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NW-1:0] num_in,
  input  wire logic [DW-1:0] den_in,
  input  wire logic          neg_in,
  input  wire logic          zero_in,
  output logic signed [PW-1:0] res_out
);

  logic [NW-1:0] n_r   [NW];
  logic [DW-1:0] d_r   [NW];
  logic [DW-1:0] rem_r [NW];
  logic [NW-1:0] q_r   [NW];
  logic          neg_r [NW];
  logic          zero_r [NW];

  for (genvar k = 0; k < NW; k++) begin : g_bit
    logic [NW-1:0] n_p, q_p;
    logic [DW-1:0] d_p, rem_p;
    logic          neg_p, zero_p;
    logic [DW:0]   sh;
    logic          ge;
    logic [NW-1:0] q_n;

    always_comb begin
      if (k == 0) begin
        n_p = num_in; d_p = den_in; rem_p = '0; q_p = '0;
        neg_p = neg_in; zero_p = zero_in;
      end else begin
        n_p = n_r[(k == 0) ? 0 : k - 1];
        d_p = d_r[(k == 0) ? 0 : k - 1];
        rem_p = rem_r[(k == 0) ? 0 : k - 1];
        q_p = q_r[(k == 0) ? 0 : k - 1];
        neg_p = neg_r[(k == 0) ? 0 : k - 1];
        zero_p = zero_r[(k == 0) ? 0 : k - 1];
      end
      sh = {rem_p, n_p[NW-1-k]};
      ge = sh >= {1'b0, d_p};
      q_n = q_p;
      q_n[NW-1-k] = ge;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k]    <= n_p;
        d_r[k]    <= d_p;
        rem_r[k]  <= ge ? DW'(sh - {1'b0, d_p}) : DW'(sh);
        q_r[k]    <= q_n;
        neg_r[k]  <= neg_p;
        zero_r[k] <= zero_p;
      end
    end
  end

  logic signed [MW-1:0] qs;
  always_comb begin
    qs = signed'(MW'(q_r[NW-1]));
    if (neg_r[NW-1]) qs = -qs;
    res_out = zero_r[NW-1] ? '0 : sat32(qs);
  end

endmodule
`default_nettype wire

// ===== tb/euler_model_normal_matrix_top_tb.sv =====
// Self-checking testbench for the Euler model and normal matrix block.
`timescale 1ns / 1ps
module euler_model_normal_matrix_top_tb;
  import emnm_pkg::*;

  localparam int STAGES = 16;
  localparam int DRAIN_CYCLES = STAGES + 80;
  localparam longint CYCLE_LIMIT = 600000;
  localparam int N_RANDOM = 450;
  localparam int N_DIRECTED = 16;

  typedef struct {
    logic signed [AW-1:0] hdg, pit, bnk;
    logic signed [SW-1:0] us, ax, ay, az;
    logic signed [PW-1:0] px, py, pz;
    logic nrm;
    bit pos_known;   // column 3 typed in below
    logic signed [PW-1:0] pos_e0, pos_e1, pos_e2;
    bit nrm_zero;    // all normal entries known to be zero
  } object_t;

  typedef struct {
    logic kind;
    logic [1:0] col;
    logic signed [PW-1:0] e0, e1, e2, e3;
    logic last;
  } column_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [AW-1:0] in_heading_angle = '0, in_pitch_angle = '0, in_bank_angle = '0;
  logic signed [SW-1:0] in_uniform_scale = '0, in_axis_scale_x = '0;
  logic signed [SW-1:0] in_axis_scale_y = '0, in_axis_scale_z = '0;
  logic signed [PW-1:0] in_position_x = '0, in_position_y = '0, in_position_z = '0;
  logic in_want_normal = 1'b0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic out_matrix_kind;
  logic [1:0] out_column_number;
  logic signed [PW-1:0] out_entry_0, out_entry_1, out_entry_2, out_entry_3;
  logic out_last_column;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic signed [SW-1:0] cfg_data = '0;

  euler_model_normal_matrix_top #(.CORDIC_STAGES(STAGES)) dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  column_t pending_cols[$];
  longint vert_scale;
  int errors = 0;
  longint cycles = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  longint arctan_tab[30] = '{843314857, 497837829, 263043837, 133525159, 67021687,
    33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  task automatic sin_cos(input longint ang, output longint s, output longint c);
    longint a, x, y, z, t;
    bit flip;
    a = ang % 46080;
    flip = 1'b0;
    if (a < 0) a += 46080;
    if (a > 23040) a -= 46080;
    if (a > 11520) begin
      a = 23040 - a;
      flip = 1'b1;
    end else if (a < -11520) begin
      a = -23040 - a;
      flip = 1'b1;
    end
    x = 652032874;
    y = 0;
    z = a * 146409;
    for (int i = 0; i < STAGES && i < 30; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z -= arctan_tab[i];
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z += arctan_tab[i];
      end
      x = t;
    end
    s = y;
    c = flip ? -x : x;
  endtask

  function automatic longint recip_round(longint n, longint d);
    longint unsigned un, ud, q;
    un = n < 0 ? -n : n;
    ud = d < 0 ? -d : d;
    q = (2 * un + ud) / (2 * ud);
    if (q > 64'd4294967296) q = 64'd4294967296;
    return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
  endfunction

  // Append one expected column transfer at the tail.
  function automatic void queue_column(column_t c);
    pending_cols = {pending_cols, c};
  endfunction

  // Work out the column transfers for one accepted object and queue them.
  task automatic predict_columns(input object_t o);
    longint sh, ch, sp, cp, sb, cb, scl[3], e[4];
    longint rot[3][3];
    column_t c;
    sin_cos(o.hdg, sh, ch);
    sin_cos(o.pit, sp, cp);
    sin_cos(o.bnk, sb, cb);
    rot[0][0] = qmul(ch, cb) + qmul(sh, qmul(sp, sb));
    rot[0][1] = -qmul(ch, sb) + qmul(sh, qmul(sp, cb));
    rot[0][2] = qmul(sh, cp);
    rot[1][0] = qmul(cp, sb);
    rot[1][1] = qmul(cp, cb);
    rot[1][2] = -sp;
    rot[2][0] = -qmul(sh, cb) + qmul(ch, qmul(sp, sb));
    rot[2][1] = qmul(sh, sb) + qmul(ch, qmul(sp, cb));
    rot[2][2] = qmul(ch, cp);
    scl[0] = (longint'(o.us) * longint'(o.ax) + 32768) >>> 16;
    scl[1] = (longint'(o.us) * longint'(o.ay) + 32768) >>> 16;
    scl[2] = (longint'(o.us) * longint'(o.az) + 32768) >>> 16;
    for (int k = 0; k < 3; k++) begin
      c.kind = KIND_MODEL;
      c.col = 2'(k);
      c.e0 = PW'(clamp32(qmul(rot[0][k], scl[k])));
      c.e1 = PW'(clamp32(qmul(rot[1][k], scl[k])));
      c.e2 = PW'(clamp32(qmul(rot[2][k], scl[k])));
      c.e3 = 0;
      c.last = 1'b0;
      queue_column(c);
    end
    c.col = 2'd3;
    c.e0 = o.px;
    c.e1 = PW'(clamp32((longint'(o.py) * vert_scale + 32768) >>> 16));
    c.e2 = o.pz;
    c.e3 = ONE_Q16;
    c.last = !o.nrm;
    if (o.pos_known) begin
      c.e0 = o.pos_e0;
      c.e1 = o.pos_e1;
      c.e2 = o.pos_e2;
    end
    queue_column(c);
    if (o.nrm) begin
      for (int k = 0; k < 3; k++) begin
        for (int r = 0; r < 3; r++)
          e[r] = scl[k] != 0 ? clamp32(recip_round(rot[r][k] * 4, scl[k])) : 0;
        c.kind = KIND_NORMAL;
        c.col = 2'(k);
        c.e0 = PW'(e[0]);
        c.e1 = PW'(e[1]);
        c.e2 = PW'(e[2]);
        c.e3 = 0;
        c.last = (k == 2);
        if (o.nrm_zero) begin
          c.e0 = 0;
          c.e1 = 0;
          c.e2 = 0;
        end
        queue_column(c);
      end
    end
  endtask

  // Result side: check each transfer, then pick the next stall value.
  int stall_left = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    column_t x;
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_cols.size() == 0) begin
        $error("unexpected column transfer kind=%0d col=%0d", out_matrix_kind,
               out_column_number);
        errors++;
      end else begin
        x = pending_cols.pop_front();
        if (out_matrix_kind !== x.kind) begin
          $error("matrix_kind exp %0d got %0d", x.kind, out_matrix_kind); errors++;
        end
        if (out_column_number !== x.col) begin
          $error("column_number exp %0d got %0d", x.col, out_column_number); errors++;
        end
        if (out_entry_0 !== x.e0) begin
          $error("entry_0 exp %0d got %0d", x.e0, out_entry_0); errors++;
        end
        if (out_entry_1 !== x.e1) begin
          $error("entry_1 exp %0d got %0d", x.e1, out_entry_1); errors++;
        end
        if (out_entry_2 !== x.e2) begin
          $error("entry_2 exp %0d got %0d", x.e2, out_entry_2); errors++;
        end
        if (out_entry_3 !== x.e3) begin
          $error("entry_3 exp %0d got %0d", x.e3, out_entry_3); errors++;
        end
        if (out_last_column !== x.last) begin
          $error("last_column exp %0d got %0d", x.last, out_last_column); errors++;
        end
      end
    end
    if (hold_req && hold_left == 0) begin
      hold_left = 400;
      hold_req <= 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (calm || $urandom_range(99) < 65) begin
      out_stall <= 1'b0;
    end else begin
      stall_left = ($urandom_range(99) < 8) ? $urandom_range(60, 15) : $urandom_range(3);
      out_stall <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Offer one object and hold it until the transfer happens.
  task automatic offer(input object_t o);
    in_valid <= 1'b1;
    in_heading_angle <= o.hdg;
    in_pitch_angle <= o.pit;
    in_bank_angle <= o.bnk;
    in_uniform_scale <= o.us;
    in_axis_scale_x <= o.ax;
    in_axis_scale_y <= o.ay;
    in_axis_scale_z <= o.az;
    in_position_x <= o.px;
    in_position_y <= o.py;
    in_position_z <= o.pz;
    in_want_normal <= o.nrm;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_columns(o);
  endtask

  // Random gap after a transfer; a zero gap keeps valid high into the next object.
  task automatic idle_gap();
    int g;
    g = calm ? 0 : (($urandom_range(99) < 5) ? $urandom_range(40, 10)
                                             : ($urandom_range(99) < 55 ? 0
                                                                         : $urandom_range(3)));
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic write_vert_scale(input logic signed [SW-1:0] v);
    while (pending_cols.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    vert_scale = v;
  endtask

  function automatic logic signed [SW-1:0] rand_scale();
    case ($urandom_range(5))
      0: return SW'($urandom);
      1: return '0;
      2: return SW'($urandom_range(2));
      3: return SW'(int'($urandom_range(131072)) - 65536);
      default: return SW'(int'($urandom_range(393216)) - 196608);
    endcase
  endfunction

  function automatic object_t rand_object();
    object_t o;
    o = '{default: 0};
    if ($urandom_range(9) == 0) begin
      o.hdg = AW'($urandom); o.pit = AW'($urandom); o.bnk = AW'($urandom);
    end else begin
      o.hdg = AW'(int'($urandom_range(92160)) - 46080);
      o.pit = AW'(int'($urandom_range(92160)) - 46080);
      o.bnk = AW'(int'($urandom_range(92160)) - 46080);
    end
    o.us = rand_scale();
    o.ax = rand_scale();
    o.ay = rand_scale();
    o.az = rand_scale();
    o.px = $urandom;
    o.py = $urandom;
    o.pz = $urandom;
    o.nrm = 1'($urandom_range(1));
    return o;
  endfunction

  object_t dir_tab[N_DIRECTED];
  logic signed [SW-1:0] vs_phases[4] = '{24'sh7fffff, -24'sh800000, 24'sd0, 24'sd98304};

  initial begin
    object_t o;
    vert_scale = 65536;
    // hdg pit bnk | us ax ay az | px py pz | nrm | typed column 3 | zero normals
    dir_tab[0]  = '{0, 0, 0, 65536, 65536, 65536, 65536, 0, 0, 0, 1,
                    1, 0, 0, 0, 0};
    dir_tab[1]  = '{46080, -46080, 0, 65536, 65536, 65536, 65536,
                    32'sh7fffffff, -32'sh80000000, 32'sh7fffffff, 0,
                    1, 32'sh7fffffff, -32'sh80000000, 32'sh7fffffff, 0};
    dir_tab[2]  = '{17'sh0ffff, -17'sh10000, 11520, -24'sh800000, -24'sh800000,
                    24'sh7fffff, -24'sh800000, 123456, -654321, 42, 1,
                    1, 123456, -654321, 42, 0};
    dir_tab[3]  = '{23040, -23040, -11520, 0, 65536, 65536, 65536, 1, 2, 3, 1,
                    1, 1, 2, 3, 1};
    dir_tab[4]  = '{5760, 11520, -5760, 65536, 0, 0, 0, -1, -1, -1, 1,
                    1, -1, -1, -1, 1};
    dir_tab[5]  = '{-11520, 5760, 23040, 1, 1, 1, 1, 0, 0, 0, 1, 0, 0, 0, 0, 0};
    dir_tab[6]  = '{11521, -11521, 23039, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff,
                    24'sh7fffff, 0, 0, 0, 1, 0, 0, 0, 0, 0};
    dir_tab[7]  = '{1, -1, 46079, 65536, 1, -1, 2, 0, 0, 0, 1, 0, 0, 0, 0, 0};
    dir_tab[8]  = '{30000, -30000, 40000, 32768, 98304, -65536, 131072, 0, 0, 0, 0,
                    0, 0, 0, 0, 0};
    dir_tab[9]  = '{-46079, 34560, -34560, -65536, 65536, 65536, 65536, 0, 0, 0, 1,
                    0, 0, 0, 0, 0};
    dir_tab[10] = '{17'sh0aaaa, 17'sh15555, 17'sh0f0f0, 24'sh555555, 24'shaaaaaa,
                    24'sh0f0f0f, 24'shf0f0f0, 32'sh55555555, 32'shaaaaaaaa,
                    32'sh0f0f0f0f, 1, 1, 32'sh55555555, 32'shaaaaaaaa, 32'sh0f0f0f0f, 0};
    dir_tab[11] = '{17'sh15555, 17'sh0aaaa, 17'sh10f0f, 24'shaaaaaa, 24'sh555555,
                    24'shf0f0f0, 24'sh0f0f0f, 32'shaaaaaaaa, 32'sh55555555,
                    32'shf0f0f0f0, 0, 1, 32'shaaaaaaaa, 32'sh55555555, 32'shf0f0f0f0, 0};
    dir_tab[12] = '{0, 0, 0, 256, 256, 256, 256, 0, 0, 0, 1, 0, 0, 0, 0, 0};
    dir_tab[13] = '{100, 200, 300, 65536, 65536, 0, 65536, 0, 0, 0, 1, 0, 0, 0, 0, 0};
    dir_tab[14] = '{-17'sh10000, 17'sh0ffff, 0, 65536, 65536, 65536, 65536, 0, 0, 0, 0,
                    0, 0, 0, 0, 0};
    dir_tab[15] = '{11520, 11520, 11520, 65536, 65536, 65536, 65536, 0, 0, 0, 1,
                    0, 0, 0, 0, 0};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      offer(dir_tab[i]);
      idle_gap();
    end
    in_valid <= 1'b0;

    for (int ph = 0; ph < 5; ph++) begin
      if (ph < 4) write_vert_scale(vs_phases[ph]);
      else write_vert_scale(SW'($urandom));
      calm = (ph == 2);
      for (int i = 0; i < N_RANDOM / 5; i++) begin
        if (ph == 1 && i == 20) hold_req <= 1'b1;
        o = rand_object();
        offer(o);
        idle_gap();
      end
      in_valid <= 1'b0;
    end
    calm = 1'b0;

    while (pending_cols.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
